@@ design/polynomial_bisection_root_macros.svh @@
// Assertion macros used by the checker file of the bisection root finder.
`ifndef POLYNOMIAL_BISECTION_ROOT_MACROS_SVH
`define POLYNOMIAL_BISECTION_ROOT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PBR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PBR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/pbr_pkg.sv @@
// Shared constants, types and command structs of the bisection root finder.
package pbr_pkg;

    localparam int DATA_W     = 32;
    localparam int ACC_W      = 64;
    localparam int NUM_COEF   = 7;
    localparam int TERMS      = 7;
    localparam int FRAC_BITS  = 16;
    localparam int MAX_STEPS  = 64;
    localparam int CNT_W      = 7;
    localparam int COEF_IDX_W = 3;
    localparam int TOL_W      = 31;
    localparam int PADDR_W    = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [TOL_W-1:0]     TOL_RESET    = 31'd66;
    localparam logic [REG_IDX_W-1:0] REG_HALF_TOL = 3'd7;

    typedef struct packed {
        logic signed [DATA_W-1:0] lower_end;
        logic signed [DATA_W-1:0] upper_end;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] root_estimate;
        logic                     no_sign_change;
        logic [CNT_W-1:0]         iteration_count;
    } out_word_t;

    typedef logic [NUM_COEF-1:0][DATA_W-1:0] coef_bank_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL_START,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_COMBINE,
        ST_ACCUM,
        ST_EVAL_END,
        ST_CHECK,
        ST_DONE
    } ctrl_state_t;

    typedef enum logic [1:0] {
        PH_LEFT,
        PH_RIGHT,
        PH_MID
    } eval_phase_t;

    typedef struct packed {
        logic                  cap_in;
        logic                  x_right;
        logic                  x_mid;
        logic                  acc_init;
        logic                  mul_lo;
        logic                  mul_hi;
        logic                  combine;
        logic                  accum;
        logic [COEF_IDX_W-1:0] coef_idx;
        logic                  sign_load;
        logic                  take_right;
        logic                  take_left;
        logic                  cnt_inc;
        logic                  res_load;
        logic                  res_nsc;
    } dp_cmd_t;

    typedef struct packed {
        logic sign_differs;
        logic width_ok;
        logic cnt_max;
    } dp_stat_t;

endpackage

@@ design/pbr_regs.sv @@
// APB register file: polynomial coefficients and half tolerance.
module pbr_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pbr_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output pbr_pkg::coef_bank_t            coefs,
    output logic [pbr_pkg::TOL_W-1:0]      half_tol
);

    logic [pbr_pkg::REG_IDX_W-1:0] idx;
    logic                          wr_en;
    pbr_pkg::coef_bank_t           coef_reg;
    logic [pbr_pkg::TOL_W-1:0]     half_tol_reg;

    assign idx    = paddr[pbr_pkg::PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg     <= '0;
            half_tol_reg <= pbr_pkg::TOL_RESET;
        end
        else if (wr_en)
        begin
            for (int k = 0; k < pbr_pkg::NUM_COEF; k++)
            begin
                if (idx == pbr_pkg::REG_IDX_W'(k))
                begin
                    coef_reg[k] <= pwdata;
                end
            end
            if (idx == pbr_pkg::REG_HALF_TOL)
            begin
                half_tol_reg <= pwdata[pbr_pkg::TOL_W-1:0];
            end
        end
    end

    always_comb
    begin
        if (idx == pbr_pkg::REG_HALF_TOL)
        begin
            prdata = {1'b0, half_tol_reg};
        end
        else
        begin
            prdata = coef_reg[idx];
        end
    end

    assign coefs    = coef_reg;
    assign half_tol = half_tol_reg;

endmodule

@@ design/pbr_ctrl.sv @@
// Sequencer: Horner steps, endpoint evaluations, halving loop and result handoff.
module pbr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    output logic              result_valid,
    input  logic              result_ready,
    input  pbr_pkg::dp_stat_t stat,
    output pbr_pkg::dp_cmd_t  cmd
);

    pbr_pkg::ctrl_state_t          state_reg, state_next;
    pbr_pkg::eval_phase_t          phase_reg, phase_next;
    logic [pbr_pkg::COEF_IDX_W-1:0] k_reg, k_next;
    logic                          nsc_reg, nsc_next;
    logic                          out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pbr_pkg::ST_IDLE;
            phase_reg     <= pbr_pkg::PH_LEFT;
            k_reg         <= '0;
            nsc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            k_reg         <= k_next;
            nsc_reg       <= nsc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        k_next     = k_reg;
        nsc_next   = nsc_reg;
        cmd        = '0;
        cmd.coef_idx = k_reg;
        cmd.res_nsc  = nsc_reg;

        out_valid_next = out_valid_reg && !result_ready;

        case (state_reg)
            pbr_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.cap_in = 1'b1;
                    phase_next = pbr_pkg::PH_LEFT;
                    state_next = pbr_pkg::ST_EVAL_START;
                end
            end
            pbr_pkg::ST_EVAL_START:
            begin
                cmd.acc_init = 1'b1;
                if (pbr_pkg::TERMS > 1)
                begin
                    k_next     = pbr_pkg::COEF_IDX_W'(pbr_pkg::TERMS - 2);
                    state_next = pbr_pkg::ST_MUL_LO;
                end
                else
                begin
                    state_next = pbr_pkg::ST_EVAL_END;
                end
            end
            pbr_pkg::ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = pbr_pkg::ST_MUL_HI;
            end
            pbr_pkg::ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = pbr_pkg::ST_COMBINE;
            end
            pbr_pkg::ST_COMBINE:
            begin
                cmd.combine = 1'b1;
                state_next  = pbr_pkg::ST_ACCUM;
            end
            pbr_pkg::ST_ACCUM:
            begin
                cmd.accum = 1'b1;
                if (k_reg == '0)
                begin
                    state_next = pbr_pkg::ST_EVAL_END;
                end
                else
                begin
                    k_next     = k_reg - 1'b1;
                    state_next = pbr_pkg::ST_MUL_LO;
                end
            end
            pbr_pkg::ST_EVAL_END:
            begin
                case (phase_reg)
                    pbr_pkg::PH_LEFT:
                    begin
                        cmd.sign_load = 1'b1;
                        cmd.x_right   = 1'b1;
                        phase_next    = pbr_pkg::PH_RIGHT;
                        state_next    = pbr_pkg::ST_EVAL_START;
                    end
                    pbr_pkg::PH_RIGHT:
                    begin
                        if (stat.sign_differs)
                        begin
                            state_next = pbr_pkg::ST_CHECK;
                        end
                        else
                        begin
                            nsc_next   = 1'b1;
                            state_next = pbr_pkg::ST_DONE;
                        end
                    end
                    default:
                    begin
                        // keep the half whose ends differ in sign
                        if (stat.sign_differs)
                        begin
                            cmd.take_right = 1'b1;
                        end
                        else
                        begin
                            cmd.take_left = 1'b1;
                            cmd.sign_load = 1'b1;
                        end
                        state_next = pbr_pkg::ST_CHECK;
                    end
                endcase
            end
            pbr_pkg::ST_CHECK:
            begin
                if (stat.width_ok || stat.cnt_max)
                begin
                    nsc_next   = 1'b0;
                    state_next = pbr_pkg::ST_DONE;
                end
                else
                begin
                    cmd.cnt_inc = 1'b1;
                    cmd.x_mid   = 1'b1;
                    phase_next  = pbr_pkg::PH_MID;
                    state_next  = pbr_pkg::ST_EVAL_START;
                end
            end
            pbr_pkg::ST_DONE:
            begin
                // hold until the output register is free or being drained
                if (!out_valid_reg || result_ready)
                begin
                    cmd.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = pbr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pbr_pkg::ST_IDLE;
            end
        endcase
    end

    assign item_ready   = (state_reg == pbr_pkg::ST_IDLE);
    assign result_valid = out_valid_reg;

endmodule

@@ design/pbr_dp.sv @@
// Datapath: interval registers, shared multiplier, Horner accumulator, result register.
module pbr_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pbr_pkg::dp_cmd_t          cmd,
    input  pbr_pkg::in_word_t         item,
    input  pbr_pkg::coef_bank_t       coefs,
    input  logic [pbr_pkg::TOL_W-1:0] half_tol,
    output pbr_pkg::dp_stat_t         stat,
    output pbr_pkg::out_word_t        result
);

    localparam int DW   = pbr_pkg::DATA_W;
    localparam int AW   = pbr_pkg::ACC_W;
    localparam int SUMW = AW + DW + 1;

    localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

    logic signed [DW-1:0]      left_reg, right_reg, x_reg;
    logic                      left_sign_reg;
    logic [pbr_pkg::CNT_W-1:0] cnt_reg;
    logic signed [AW-1:0]      acc_reg;
    logic signed [AW-1:0]      phi_reg;
    logic signed [AW:0]        plo_reg;
    logic signed [SUMW-1:0]    sum_reg;
    pbr_pkg::out_word_t        result_reg;

    logic signed [DW:0]        mult_a, mult_b;
    logic signed [2*DW+1:0]    mult_p;
    logic signed [SUMW-1:0]    phi_ext, plo_ext, sum_comb, sum_sh;
    logic                      sh_ovf;
    logic signed [AW-1:0]      prod_sat;
    logic signed [AW:0]        acc_sum;
    logic signed [AW-1:0]      acc_next;
    logic signed [DW-1:0]      coef_sel;
    logic signed [DW:0]        lr_sum, lr_diff;
    logic [DW:0]               lr_width;
    logic signed [DW-1:0]      mid;

    // one shared 33x33 multiplier: low word unsigned, high word signed
    assign mult_a = cmd.mul_hi ? {acc_reg[AW-1], acc_reg[AW-1:DW]}
                               : {1'b0, acc_reg[DW-1:0]};
    assign mult_b = {x_reg[DW-1], x_reg};
    assign mult_p = mult_a * mult_b;

    assign phi_ext  = {{(SUMW-AW){phi_reg[AW-1]}}, phi_reg};
    assign plo_ext  = {{(SUMW-AW-1){plo_reg[AW]}}, plo_reg};
    assign sum_comb = (phi_ext <<< DW) + plo_ext;

    // floor shift, then saturate to 64 bits and add the coefficient
    assign sum_sh   = sum_reg >>> pbr_pkg::FRAC_BITS;
    assign sh_ovf   = !((&sum_sh[SUMW-1:AW-1]) || !(|sum_sh[SUMW-1:AW-1]));
    assign prod_sat = sh_ovf ? (sum_sh[SUMW-1] ? ACC_MIN : ACC_MAX) : sum_sh[AW-1:0];
    assign coef_sel = coefs[cmd.coef_idx];
    assign acc_sum  = {prod_sat[AW-1], prod_sat} + {{(AW-DW+1){coef_sel[DW-1]}}, coef_sel};
    assign acc_next = (acc_sum[AW] != acc_sum[AW-1]) ? (acc_sum[AW] ? ACC_MIN : ACC_MAX)
                                                     : acc_sum[AW-1:0];

    assign lr_sum   = {left_reg[DW-1], left_reg} + {right_reg[DW-1], right_reg};
    assign lr_diff  = {left_reg[DW-1], left_reg} - {right_reg[DW-1], right_reg};
    assign lr_width = lr_diff[DW] ? -lr_diff : lr_diff;
    assign mid      = lr_sum[DW:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_sign_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cmd.cap_in)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.sign_load)
            begin
                left_sign_reg <= acc_reg[AW-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_in)
        begin
            left_reg  <= item.lower_end;
            right_reg <= item.upper_end;
            x_reg     <= item.lower_end;
        end
        else
        begin
            if (cmd.x_right)
            begin
                x_reg <= right_reg;
            end
            if (cmd.x_mid)
            begin
                x_reg <= mid;
            end
            if (cmd.take_right)
            begin
                right_reg <= x_reg;
            end
            if (cmd.take_left)
            begin
                left_reg <= x_reg;
            end
        end

        if (cmd.acc_init)
        begin
            acc_reg <= {{(AW-DW){coefs[pbr_pkg::TERMS-1][DW-1]}},
                        coefs[pbr_pkg::TERMS-1]};
        end
        else if (cmd.accum)
        begin
            acc_reg <= acc_next;
        end

        if (cmd.mul_lo)
        begin
            plo_reg <= mult_p[AW:0];
        end
        if (cmd.mul_hi)
        begin
            phi_reg <= mult_p[AW-1:0];
        end
        if (cmd.combine)
        begin
            sum_reg <= sum_comb;
        end

        if (cmd.res_load)
        begin
            if (cmd.res_nsc)
            begin
                result_reg.root_estimate   <= '0;
                result_reg.no_sign_change  <= 1'b1;
                result_reg.iteration_count <= '0;
            end
            else
            begin
                result_reg.root_estimate   <= mid;
                result_reg.no_sign_change  <= 1'b0;
                result_reg.iteration_count <= cnt_reg;
            end
        end
    end

    assign stat.sign_differs = acc_reg[AW-1] != left_sign_reg;
    assign stat.width_ok     = lr_width <= {1'b0, half_tol, 1'b0};
    assign stat.cnt_max      = cnt_reg >= pbr_pkg::CNT_W'(pbr_pkg::MAX_STEPS);
    assign result            = result_reg;

endmodule

@@ design/polynomial_bisection_root.sv @@
// Top level of the bisection root finder: register file, sequencer and datapath.
//
// Usage:
//   Input channel (item_valid/item_ready/item) carries one word with the two
//   interval ends, signed Q16.16, in either order. Output channel
//   (result_valid/result_ready/result) returns one word per input: the final
//   midpoint, the no-sign-change flag and the number of halvings.
//   Coefficients coef_x0..coef_x6 and half_tolerance sit on the APB port at
//   byte addresses 0x00..0x1C; write them only while the block is idle.
// Operation:
//   Each Horner term runs on the single shared 33x33 multiplier as low
//   partial, high partial, combine and saturating add, between a load step
//   and a finish step. N, the halving count, runs 0..64 and is 0 when both
//   ends share a sign; item_ready rises with result_valid, so a new word is
//   accepted only after the last one has reached the output register.
// Reset:
//   rst_n clears sequencer, output valid and counters; coefficients go to zero.
// Stall:
//   The result waits in an output register while the next word starts; a
//   second result holds in the sequencer until the first is taken.
module polynomial_bisection_root (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  pbr_pkg::in_word_t           item,
    output logic                        result_valid,
    input  logic                        result_ready,
    output pbr_pkg::out_word_t          result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pbr_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    pbr_pkg::coef_bank_t       coefs;
    logic [pbr_pkg::TOL_W-1:0] half_tol;
    pbr_pkg::dp_cmd_t          cmd;
    pbr_pkg::dp_stat_t         stat;

    // configuration registers; half_tolerance resets to 66
    pbr_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .coefs    (coefs),
        .half_tol (half_tol)
    );

    // sequencer: owns the handshakes and drives the datapath commands
    pbr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    // datapath: interval, multiplier, accumulator and output word
    pbr_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .item     (item),
        .coefs    (coefs),
        .half_tol (half_tol),
        .stat     (stat),
        .result   (result)
    );

endmodule

@@ design/pbr_checker.sv @@
// Port-level checker of the bisection root finder and its bind.
`include "polynomial_bisection_root_macros.svh"

module pbr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_ready,
    input logic               result_valid,
    input logic               result_ready,
    input pbr_pkg::out_word_t result
);

    `PBR_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result), "stalled result word dropped or changed")
    `PBR_ASSERT_NXT(a_busy_after_accept, item_valid && item_ready, !item_ready, "input ready while a word is in work")
    `PBR_ASSERT_IMP(a_nsc_clean, result_valid && result.no_sign_change, result.root_estimate == 0 && result.iteration_count == 0, "no-sign-change word carries root or count")
    `PBR_ASSERT_IMP(a_count_bound, result_valid, result.iteration_count <= pbr_pkg::CNT_W'(pbr_pkg::MAX_STEPS), "halving count beyond limit")

endmodule

bind polynomial_bisection_root pbr_checker u_pbr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
